/* sv/serial_frame_receiver_with_fifo_assert.svh */
// ----------------------------------------------------------------------------
// Serial frame receiver assertion macros
// Shared concurrent assertion forms for the frame receiver checkers.
// ----------------------------------------------------------------------------
`ifndef SERIAL_FRAME_RECEIVER_WITH_FIFO_ASSERT_SVH
`define SERIAL_FRAME_RECEIVER_WITH_FIFO_ASSERT_SVH

// same-cycle implication
`define SFR_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// implication with a delayed consequent
`define SFR_ASSERT_LATER2(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> ##2 (cons)) \
      else $error(msg);

`endif

/* sv/cfr_pkg.sv */
// ----------------------------------------------------------------------------
// Frame receiver package
// Types and constants shared by the frame receiver modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cfr_pkg;

   localparam logic       ACT_BYTE = 1'b0;
   localparam logic       ACT_READ = 1'b1;

   localparam logic [0:0] REG_HEADER  = 1'b0;
   localparam logic [0:0] REG_TRAILER = 1'b1;

   localparam logic [7:0] HEADER_RESET  = 8'hAA;
   localparam logic [7:0] TRAILER_RESET = 8'h55;

   localparam int MSG_W   = 24;
   localparam int COUNT_W = 5;

   typedef enum logic [2:0] {
      FP_HEADER,
      FP_DATA0,
      FP_DATA1,
      FP_DATA2,
      FP_TRAILER
   } frame_pos_type;

   typedef enum logic [1:0] {
      CMD_NOP,
      CMD_PUSH,
      CMD_READ
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type         op;
      logic [MSG_W-1:0]   data;
   } cmd_type;

   typedef struct packed {
      logic               strobe;
      logic               frame_done;
      logic               frame_dropped;
      logic               read_valid;
      logic [7:0]         first_data;
      logic [7:0]         second_data;
      logic [7:0]         third_data;
      logic [COUNT_W-1:0] message_count;
   } rsp_type;

endpackage

/* sv/serial_frame_receiver_with_fifo.sv */
// ----------------------------------------------------------------------------
// Serial frame receiver with message FIFO
// Deframes header/3 data/trailer byte frames and queues the data as messages.
// ----------------------------------------------------------------------------
// Usage:
//   An input word (req_action, req_rx_byte) is taken at a rising edge with
//   start high and busy low. req_action 0 feeds a received byte to the frame
//   tracker; 1 pops the oldest stored message.
//   Every word gives exactly one result, shown for one cycle with rsp_valid
//   high once it has passed the command queue and the result register.
//   The receiver cannot hold results off; none are buffered beyond that cycle.
//   Throughput is one word per cycle: the front end, the two-entry command
//   queue and the back end each handle one word a cycle, and the back end's
//   RAM (one write port, one read port) serves the push or read of that word.
//   busy rises only if the command queue fills, which a one-word-per-cycle
//   back end does not allow in practice.
//   Header and trailer values sit in an APB register pair at 0x0 and 0x4.
//   Reset (synchronous) returns the tracker to waiting for a header, empties
//   the FIFO and restores the header and trailer values; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module serial_frame_receiver_with_fifo import cfr_pkg::*; #(
   parameter int FIFO_DEPTH = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_action,
   input  logic [7:0]          req_rx_byte,
   output logic                rsp_valid,
   output logic                rsp_frame_done,
   output logic                rsp_frame_dropped,
   output logic                rsp_read_valid,
   output logic [7:0]          rsp_first_data,
   output logic [7:0]          rsp_second_data,
   output logic [7:0]          rsp_third_data,
   output logic [COUNT_W-1:0]  rsp_message_count,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [2:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);

   logic [7:0] header_ff, trailer_ff;
   logic       csr_write;
   logic       accept;
   logic       cmd_push, q_not_empty, q_full, q_pop;
   cmd_type    front_cmd, q_head;
   rsp_type    rsp;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign prdata    = {24'd0, (paddr[2] == REG_TRAILER) ? trailer_ff : header_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff  <= HEADER_RESET;
         trailer_ff <= TRAILER_RESET;
      end else if (csr_write) begin
         if (paddr[2] == REG_HEADER) begin
            header_ff <= pwdata[7:0];
         end else begin
            trailer_ff <= pwdata[7:0];
         end
      end
   end

   assign busy   = q_full;
   assign accept = start && !busy;

   cfr_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .action       (req_action),
      .rx_byte      (req_rx_byte),
      .header_byte  (header_ff),
      .trailer_byte (trailer_ff),
      .cmd_push     (cmd_push),
      .cmd          (front_cmd)
   );

   cfr_cmdq u_cmdq (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_cmd  (front_cmd),
      .pop       (q_pop),
      .head      (q_head),
      .not_empty (q_not_empty),
      .full      (q_full)
   );

   cfr_back #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (q_not_empty),
      .cmd       (q_head),
      .pop       (q_pop),
      .rsp       (rsp)
   );

   assign rsp_valid         = rsp.strobe;
   assign rsp_frame_done    = rsp.frame_done;
   assign rsp_frame_dropped = rsp.frame_dropped;
   assign rsp_read_valid    = rsp.read_valid;
   assign rsp_first_data    = rsp.first_data;
   assign rsp_second_data   = rsp.second_data;
   assign rsp_third_data    = rsp.third_data;
   assign rsp_message_count = rsp.message_count;

endmodule

/* sv/cfr_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cfr_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem_ff[raddr];
      end
   end

endmodule

/* sv/cfr_front.sv */
// ----------------------------------------------------------------------------
// Frame receiver front end
// Tracks frame position, gathers data bytes, issues one command per word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cfr_front import cfr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic       action,
   input  logic [7:0] rx_byte,
   input  logic [7:0] header_byte,
   input  logic [7:0] trailer_byte,
   output logic       cmd_push,
   output cmd_type    cmd
);

   frame_pos_type    state_ff, state_in;
   logic [MSG_W-1:0] partial_ff, partial_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FP_HEADER;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      partial_ff <= partial_in;
   end

   always_comb begin
      state_in   = state_ff;
      partial_in = partial_ff;
      cmd_push   = accept;
      cmd.op     = CMD_NOP;
      cmd.data   = partial_ff;
      if (accept) begin
         if (action == ACT_READ) begin
            cmd.op = CMD_READ;
         end else begin
            unique case (state_ff)
               FP_HEADER: begin
                  if (rx_byte == header_byte) begin
                     state_in = FP_DATA0;
                  end
               end
               FP_DATA0: begin
                  partial_in[7:0] = rx_byte;
                  state_in        = FP_DATA1;
               end
               FP_DATA1: begin
                  partial_in[15:8] = rx_byte;
                  state_in         = FP_DATA2;
               end
               FP_DATA2: begin
                  partial_in[23:16] = rx_byte;
                  state_in          = FP_TRAILER;
               end
               FP_TRAILER: begin
                  if (rx_byte == trailer_byte) begin
                     cmd.op   = CMD_PUSH;
                     state_in = FP_HEADER;
                  end
               end
               default: begin
                  state_in = FP_HEADER;
               end
            endcase
         end
      end
   end

endmodule

/* sv/cfr_cmdq.sv */
// ----------------------------------------------------------------------------
// Command queue
// Two-entry queue between the front end and the message back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cfr_cmdq import cfr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output cmd_type head,
   output logic    not_empty,
   output logic    full
);

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign head      = slot_ff[rd_ptr_ff];
   assign not_empty = (count_ff != 2'd0);
   assign full      = (count_ff == 2'd2);

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

/* sv/cfr_back.sv */
// ----------------------------------------------------------------------------
// Message back end
// Ring of message entries; executes push, read and no-op commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cfr_back import cfr_pkg::*; #(
   parameter int FIFO_DEPTH = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   input  cmd_type cmd,
   output logic    pop,
   output rsp_type rsp
);

   localparam int AW = $clog2(FIFO_DEPTH);
   localparam int CW = $clog2(FIFO_DEPTH + 1);

   logic [AW-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [AW-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [CW+COUNT_W-1:0] count_wide;
   logic                 strobe_ff, done_ff, dropped_ff, valid_ff;
   logic                 done_in, dropped_in, valid_in;
   logic [COUNT_W-1:0]   msg_count_ff;
   logic                 ram_we, ram_re;
   logic [MSG_W-1:0]     ram_rdata;

   assign pop        = cmd_valid;
   assign count_wide = {{COUNT_W{1'b0}}, count_in};

   always_comb begin
      rd_ptr_in  = rd_ptr_ff;
      wr_ptr_in  = wr_ptr_ff;
      count_in   = count_ff;
      done_in    = 1'b0;
      dropped_in = 1'b0;
      valid_in   = 1'b0;
      ram_we     = 1'b0;
      ram_re     = 1'b0;
      if (cmd_valid) begin
         unique case (cmd.op)
            CMD_PUSH: begin
               if (count_ff == CW'(FIFO_DEPTH)) begin
                  dropped_in = 1'b1;
               end else begin
                  ram_we    = 1'b1;
                  done_in   = 1'b1;
                  count_in  = count_ff + CW'(1);
                  wr_ptr_in = (wr_ptr_ff == AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
               end
            end
            CMD_READ: begin
               if (count_ff != '0) begin
                  ram_re    = 1'b1;
                  valid_in  = 1'b1;
                  count_in  = count_ff - CW'(1);
                  rd_ptr_in = (rd_ptr_ff == AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
               end
            end
            CMD_NOP: begin
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff    <= '0;
         wr_ptr_ff    <= '0;
         count_ff     <= '0;
         strobe_ff    <= 1'b0;
         done_ff      <= 1'b0;
         dropped_ff   <= 1'b0;
         valid_ff     <= 1'b0;
         msg_count_ff <= '0;
      end else begin
         rd_ptr_ff    <= rd_ptr_in;
         wr_ptr_ff    <= wr_ptr_in;
         count_ff     <= count_in;
         strobe_ff    <= cmd_valid;
         done_ff      <= done_in;
         dropped_ff   <= dropped_in;
         valid_ff     <= valid_in;
         msg_count_ff <= cmd_valid ? count_wide[COUNT_W-1:0] : '0;
      end
   end

   cfr_ram #(
      .WIDTH (MSG_W),
      .DEPTH (FIFO_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (wr_ptr_ff),
      .wdata (cmd.data),
      .re    (ram_re),
      .raddr (rd_ptr_ff),
      .rdata (ram_rdata)
   );

   always_comb begin
      rsp.strobe        = strobe_ff;
      rsp.frame_done    = done_ff;
      rsp.frame_dropped = dropped_ff;
      rsp.read_valid    = valid_ff;
      rsp.first_data    = valid_ff ? ram_rdata[7:0]   : 8'd0;
      rsp.second_data   = valid_ff ? ram_rdata[15:8]  : 8'd0;
      rsp.third_data    = valid_ff ? ram_rdata[23:16] : 8'd0;
      rsp.message_count = msg_count_ff;
   end

endmodule

/* sv/cfr_checker.sv */
// ----------------------------------------------------------------------------
// Frame receiver port checker
// Port-level checks on word timing and result fields, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "serial_frame_receiver_with_fifo_assert.svh"

module cfr_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_valid,
   input logic       rsp_frame_done,
   input logic       rsp_frame_dropped,
   input logic       rsp_read_valid,
   input logic [7:0] rsp_first_data,
   input logic [7:0] rsp_second_data,
   input logic [7:0] rsp_third_data
);

   logic took_word;
   logic any_flag;
   logic any_data;

   assign took_word = start && !busy;
   assign any_flag  = rsp_frame_done || rsp_frame_dropped || rsp_read_valid;
   assign any_data  = (rsp_first_data != 8'd0) || (rsp_second_data != 8'd0) ||
                      (rsp_third_data != 8'd0);

   `SFR_ASSERT_LATER2(a_word_gives_result, took_word, rsp_valid, "accepted word gave no result")
   `SFR_ASSERT_NOW(a_result_has_word, rsp_valid, $past(took_word, 2), "result without a word")
   `SFR_ASSERT_NOW(a_flags_need_strobe, !rsp_valid, !any_flag, "flag without strobe")
   `SFR_ASSERT_NOW(a_no_data_without_read, rsp_valid && !rsp_read_valid, !any_data, "stray data")

endmodule

bind serial_frame_receiver_with_fifo cfr_checker u_cfr_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_valid         (rsp_valid),
   .rsp_frame_done    (rsp_frame_done),
   .rsp_frame_dropped (rsp_frame_dropped),
   .rsp_read_valid    (rsp_read_valid),
   .rsp_first_data    (rsp_first_data),
   .rsp_second_data   (rsp_second_data),
   .rsp_third_data    (rsp_third_data)
);

/* bench/serial_frame_receiver_with_fifo_tb.sv */
// ----------------------------------------------------------------------------
// Serial frame receiver with message FIFO - testbench
// Feeds byte and read words through the command port, sweeps header/trailer
// values over the APB registers, and checks every result word against a
// cycle-free model of the deframer and its message ring.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module serial_frame_receiver_with_fifo_tb;
   import cfr_pkg::*;

   localparam int FIFO_DEPTH = 16;

   // deframer + message ring model; holds the result words still owed
   class frame_fifo_checker;
      logic [7:0]       header_value;
      logic [7:0]       trailer_value;
      frame_pos_type    position;
      logic [7:0]       gathered [3];
      logic [MSG_W-1:0] ring [FIFO_DEPTH];
      int               rd_index;
      int               wr_index;
      int               held;
      rsp_type          owed_results [$];
      int               errors;

      function new();
         header_value  = HEADER_RESET;
         trailer_value = TRAILER_RESET;
         position      = FP_HEADER;
         rd_index      = 0;
         wr_index      = 0;
         held          = 0;
         errors        = 0;
      endfunction

      function void set_register(logic [0:0] idx, logic [7:0] value);
         if (idx == REG_HEADER)
            header_value = value;
         else
            trailer_value = value;
      endfunction

      function void take_word(logic action, logic [7:0] rx);
         rsp_type r;
         r        = '0;
         r.strobe = 1'b1;
         if (action == ACT_BYTE) begin
            case (position)
               FP_HEADER: begin
                  if (rx == header_value)
                     position = FP_DATA0;
               end
               FP_DATA0: begin
                  gathered[0] = rx;
                  position = FP_DATA1;
               end
               FP_DATA1: begin
                  gathered[1] = rx;
                  position = FP_DATA2;
               end
               FP_DATA2: begin
                  gathered[2] = rx;
                  position = FP_TRAILER;
               end
               FP_TRAILER: begin
                  if (rx == trailer_value) begin
                     position = FP_HEADER;
                     if (held >= FIFO_DEPTH) begin
                        r.frame_dropped = 1'b1;
                     end else begin
                        ring[wr_index] = {gathered[2], gathered[1], gathered[0]};
                        wr_index = (wr_index + 1) % FIFO_DEPTH;
                        held++;
                        r.frame_done = 1'b1;
                     end
                  end
               end
               default: position = FP_HEADER;
            endcase
         end else if (held != 0) begin
            {r.third_data, r.second_data, r.first_data} = ring[rd_index];
            rd_index = (rd_index + 1) % FIFO_DEPTH;
            held--;
            r.read_valid = 1'b1;
         end
         r.message_count = held[COUNT_W-1:0];
         owed_results.push_back(r);
      endfunction

      function void compare(string field, int want, int got);
         if (want != got) begin
            $display("%0t: %s mismatch, expected %0d (0x%0h), actual %0d (0x%0h)",
                     $time, field, want, want, got, got);
            errors++;
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (owed_results.size() == 0) begin
            $display("%0t: result word with nothing expected, actual %p", $time, got);
            errors++;
         end else begin
            want = owed_results.pop_front();
            compare("frame_done",    want.frame_done,    got.frame_done);
            compare("frame_dropped", want.frame_dropped, got.frame_dropped);
            compare("read_valid",    want.read_valid,    got.read_valid);
            compare("first_data",    want.first_data,    got.first_data);
            compare("second_data",   want.second_data,   got.second_data);
            compare("third_data",    want.third_data,    got.third_data);
            compare("message_count", want.message_count, got.message_count);
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic               req_action = ACT_BYTE;
   logic [7:0]         req_rx_byte = 8'h00;
   logic               rsp_valid;
   logic               rsp_frame_done;
   logic               rsp_frame_dropped;
   logic               rsp_read_valid;
   logic [7:0]         rsp_first_data;
   logic [7:0]         rsp_second_data;
   logic [7:0]         rsp_third_data;
   logic [COUNT_W-1:0] rsp_message_count;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [2:0]         paddr = '0;
   logic [31:0]        pwdata = '0;
   logic [31:0]        prdata;
   logic               pready;

   frame_fifo_checker  fifo_check;
   int                 counted_words;
   bit                 use_gaps;
   int                 read_pct;

   serial_frame_receiver_with_fifo #(.FIFO_DEPTH(FIFO_DEPTH)) dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_action        (req_action),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_frame_done    (rsp_frame_done),
      .rsp_frame_dropped (rsp_frame_dropped),
      .rsp_read_valid    (rsp_read_valid),
      .rsp_first_data    (rsp_first_data),
      .rsp_second_data   (rsp_second_data),
      .rsp_third_data    (rsp_third_data),
      .rsp_message_count (rsp_message_count),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   always @(posedge clock) begin
      rsp_type got;
      if (!reset && rsp_valid) begin
         got = {1'b1, rsp_frame_done, rsp_frame_dropped, rsp_read_valid,
                rsp_first_data, rsp_second_data, rsp_third_data, rsp_message_count};
         fifo_check.check_result(got);
      end
   end

   // start stays high if the caller sends again right away
   task automatic send_word(logic action, logic [7:0] rx);
      start       <= 1'b1;
      req_action  <= action;
      req_rx_byte <= rx;
      do @(posedge clock); while (busy);
      fifo_check.take_word(action, rx);
   endtask

   task automatic random_gap();
      int n;
      int roll;
      roll = $urandom_range(99);
      if (!use_gaps || roll < 45)
         n = 0;
      else if (roll < 96)
         n = $urandom_range(1, 3);
      else
         n = $urandom_range(20, 50);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic put_word(logic action, logic [7:0] rx, bit counts);
      send_word(action, rx);
      if (counts)
         counted_words++;
      random_gap();
   endtask

   task automatic wait_drained();
      int guard;
      guard = 0;
      start <= 1'b0;
      while (fifo_check.owed_results.size() != 0 && guard < 1000) begin
         @(posedge clock);
         guard++;
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(logic [0:0] idx, logic [7:0] value);
      start   <= 1'b0;
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= {idx, 2'b00};
      pwdata  <= {24'($urandom_range(0, 32'h00FF_FFFF)), value};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      fifo_check.set_register(idx, value);
      @(posedge clock);
   endtask

   function automatic logic [7:0] pick_data();
      case ($urandom_range(7))
         0: return fifo_check.header_value;
         1: return fifo_check.trailer_value;
         2: return 8'h00;
         3: return 8'hFF;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   task automatic maybe_read();
      if ($urandom_range(99) < read_pct)
         put_word(ACT_READ, 8'($urandom_range(255)), 1'b1);
   endtask

   // optional noise, header, three data bytes; unless cut short, optional junk and trailer; reads mixed in
   task automatic random_frame();
      logic [7:0] b;
      int         n;
      if ($urandom_range(99) < 20) begin
         n = $urandom_range(1, 3);
         repeat (n) begin
            b = 8'($urandom_range(255));
            if (b == fifo_check.header_value)
               b[0] = ~b[0];
            put_word(ACT_BYTE, b, 1'b1);
         end
      end
      maybe_read();
      put_word(ACT_BYTE, fifo_check.header_value, 1'b1);
      repeat (3) begin
         maybe_read();
         put_word(ACT_BYTE, pick_data(), 1'b1);
      end
      if ($urandom_range(99) < 8)
         return;
      if ($urandom_range(99) < 15) begin
         n = $urandom_range(1, 2);
         repeat (n) begin
            b = 8'($urandom_range(255));
            if (b == fifo_check.trailer_value)
               b[0] = ~b[0];
            put_word(ACT_BYTE, b, 1'b1);
         end
      end
      maybe_read();
      put_word(ACT_BYTE, fifo_check.trailer_value, 1'b1);
   endtask

   task automatic directed_words();
      use_gaps = 1'b0;
      put_word(ACT_READ, 8'hFF, 1'b1);
      put_word(ACT_BYTE, 8'h00, 1'b1);
      put_word(ACT_BYTE, 8'hFF, 1'b1);
      put_word(ACT_BYTE, TRAILER_RESET, 1'b1);
      put_word(ACT_BYTE, HEADER_RESET, 1'b1);
      put_word(ACT_BYTE, HEADER_RESET, 1'b1);
      put_word(ACT_BYTE, 8'h00, 1'b1);
      put_word(ACT_READ, 8'h00, 1'b1);
      put_word(ACT_BYTE, 8'hFF, 1'b1);
      put_word(ACT_BYTE, 8'h12, 1'b1);
      put_word(ACT_BYTE, HEADER_RESET, 1'b1);
      put_word(ACT_BYTE, TRAILER_RESET, 1'b1);
      put_word(ACT_BYTE, HEADER_RESET, 1'b1);
      put_word(ACT_BYTE, 8'hFF, 1'b1);
      put_word(ACT_BYTE, 8'h00, 1'b1);
      put_word(ACT_BYTE, TRAILER_RESET, 1'b1);
      put_word(ACT_BYTE, TRAILER_RESET, 1'b1);
      put_word(ACT_READ, 8'h00, 1'b1);
      put_word(ACT_READ, 8'hA5, 1'b1);
      put_word(ACT_READ, 8'h5A, 1'b1);
      wait_drained();
   endtask

   initial begin
      logic [7:0] hdr_set [5];
      logic [7:0] trl_set [5];
      int         chunk;
      int         chunk_end;
      int         phase_end;
      int         extra_tail;

      fifo_check    = new();
      counted_words = 0;
      use_gaps      = 1'b0;
      read_pct      = 17;

      hdr_set[0] = HEADER_RESET;  trl_set[0] = TRAILER_RESET;
      hdr_set[1] = 8'h00;         trl_set[1] = 8'hFF;
      hdr_set[2] = 8'hFF;         trl_set[2] = 8'h00;
      hdr_set[3] = 8'($urandom_range(255));
      trl_set[3] = 8'($urandom_range(255));
      hdr_set[4] = 8'($urandom_range(255));
      trl_set[4] = hdr_set[4];

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      directed_words();

      for (int phase = 0; phase < 5; phase++) begin
         wait_drained();
         csr_write(REG_HEADER, hdr_set[phase]);
         csr_write(REG_TRAILER, trl_set[phase]);
         @(posedge clock);
         phase_end = counted_words + 200;
         chunk = 0;
         while (counted_words < phase_end) begin
            case (chunk)
               0: read_pct = 2;
               1: read_pct = 55;
               default: begin
                  case ($urandom_range(2))
                     0: read_pct = 2;
                     1: read_pct = 17;
                     default: read_pct = 50;
                  endcase
               end
            endcase
            use_gaps  = 1'($urandom_range(1));
            chunk_end = counted_words + 40;
            while (counted_words < chunk_end)
               random_frame();
            if ($urandom_range(99) < 30)
               wait_drained();
            chunk++;
         end
      end

      wait_drained();
      extra_tail = fifo_check.owed_results.size();
      if (extra_tail != 0) begin
         $display("%0t: %0d result words never arrived", $time, extra_tail);
         fifo_check.errors++;
      end
      repeat (10) @(posedge clock);
      if (fifo_check.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
